>>> rtl/prs80_pkg.sv
// prs80_pkg: shared types, constants and round functions for the present-80 cipher unit
// no dependencies
`timescale 1ns / 1ps
package prs80_pkg;

  localparam int RoundCount = 31;
  localparam int RcW = 5;
  localparam int BlockW = 64;
  localparam int KeyW = 80;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] REG_KEY_UPPER = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_KEY_LOWER = 1'b1;

  localparam logic FUNC_ENC = 1'b0;
  localparam logic FUNC_DEC = 1'b1;

  typedef logic [BlockW-1:0] block_t;
  typedef logic [KeyW-1:0] key_t;

  typedef struct packed {
    logic   func;
    block_t data;
  } item_t;

  function automatic logic [3:0] sbox_fwd(input logic [3:0] x);
    logic [3:0] y;
    case (x)
      4'h0: y = 4'hC;
      4'h1: y = 4'h5;
      4'h2: y = 4'h6;
      4'h3: y = 4'hB;
      4'h4: y = 4'h9;
      4'h5: y = 4'h0;
      4'h6: y = 4'hA;
      4'h7: y = 4'hD;
      4'h8: y = 4'h3;
      4'h9: y = 4'hE;
      4'hA: y = 4'hF;
      4'hB: y = 4'h8;
      4'hC: y = 4'h4;
      4'hD: y = 4'h7;
      4'hE: y = 4'h1;
      default: y = 4'h2;
    endcase
    return y;
  endfunction

  function automatic logic [3:0] sbox_inv(input logic [3:0] x);
    logic [3:0] y;
    case (x)
      4'h0: y = 4'h5;
      4'h1: y = 4'hE;
      4'h2: y = 4'hF;
      4'h3: y = 4'h8;
      4'h4: y = 4'hC;
      4'h5: y = 4'h1;
      4'h6: y = 4'h2;
      4'h7: y = 4'hD;
      4'h8: y = 4'hB;
      4'h9: y = 4'h4;
      4'hA: y = 4'h6;
      4'hB: y = 4'h3;
      4'hC: y = 4'h0;
      4'hD: y = 4'h7;
      4'hE: y = 4'h9;
      default: y = 4'hA;
    endcase
    return y;
  endfunction

  function automatic int perm_dest(input int j);
    return (j == 63) ? 63 : ((16 * j) % 63);
  endfunction

  function automatic block_t enc_round(input block_t s, input block_t rk);
    block_t x;
    block_t y;
    block_t r;
    x = s ^ rk;
    for (int n = 0; n < 16; n++) y[4*n +: 4] = sbox_fwd(x[4*n +: 4]);
    for (int j = 0; j < 64; j++) r[perm_dest(j)] = y[j];
    return r;
  endfunction

  function automatic block_t dec_round(input block_t s, input block_t rk);
    block_t x;
    block_t y;
    block_t r;
    x = s ^ rk;
    for (int j = 0; j < 64; j++) y[j] = x[perm_dest(j)];
    for (int n = 0; n < 16; n++) r[4*n +: 4] = sbox_inv(y[4*n +: 4]);
    return r;
  endfunction

  // one key schedule update, i is the round counter
  function automatic key_t key_update(input key_t k, input logic [RcW-1:0] i);
    key_t n;
    n = {k[18:0], k[79:19]};
    n[79:76] = sbox_fwd(n[79:76]);
    n[19:15] = n[19:15] ^ i;
    return n;
  endfunction

endpackage

>>> rtl/prs80_stream_if.sv
// prs80_stream_if: valid/ready channel carrying a payload
// depends on nothing
`timescale 1ns / 1ps
interface prs80_stream_if #(parameter int W = 64);
  logic         valid;
  logic         ready;
  logic [W-1:0] payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/prs80_key_sched.sv
// prs80_key_sched: key registers and precomputed round keys for both directions
// depends on prs80_pkg
`timescale 1ns / 1ps
module prs80_key_sched (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [prs80_pkg::CfgIdxW-1:0]       cfg_idx,
  input  logic [prs80_pkg::CfgDataW-1:0]      cfg_data,
  output prs80_pkg::block_t                   rk_o [prs80_pkg::RoundCount+1]
);

  logic [63:0] key_upper_r;
  logic [15:0] key_lower_r;
  prs80_pkg::key_t ks_r [prs80_pkg::RoundCount+1];
  prs80_pkg::key_t ks_nxt [prs80_pkg::RoundCount+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_upper_r <= '0;
      key_lower_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        prs80_pkg::REG_KEY_UPPER: key_upper_r <= cfg_data;
        prs80_pkg::REG_KEY_LOWER: key_lower_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // one schedule step per register level, settles while idle after a write
  always_comb begin
    ks_nxt[0] = {key_upper_r, key_lower_r};
    for (int i = 1; i <= prs80_pkg::RoundCount; i++)
      ks_nxt[i] = prs80_pkg::key_update(ks_r[i-1], prs80_pkg::RcW'(i));
  end

  always_ff @(posedge clk) begin
    ks_r <= ks_nxt;
  end

  always_comb begin
    for (int i = 0; i <= prs80_pkg::RoundCount; i++) rk_o[i] = ks_r[i][79:16];
  end

endmodule

>>> rtl/prs80_round_pipe.sv
// prs80_round_pipe: one round per stage, stalls as a whole when the output is held
// depends on prs80_pkg
`timescale 1ns / 1ps
module prs80_round_pipe (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_vld,
  input  prs80_pkg::item_t    in_item,
  input  prs80_pkg::block_t   rk [prs80_pkg::RoundCount+1],
  output logic                out_vld,
  output prs80_pkg::item_t    out_item
);

  localparam int N = prs80_pkg::RoundCount;

  logic             vld_r [N+1];
  prs80_pkg::item_t st_r  [N+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= N; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_vld;
      for (int i = 1; i <= N; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= in_item;
      for (int i = 1; i <= N; i++) begin
        st_r[i].func <= st_r[i-1].func;
        if (st_r[i-1].func == prs80_pkg::FUNC_ENC)
          st_r[i].data <= prs80_pkg::enc_round(st_r[i-1].data, rk[i-1]);
        else
          st_r[i].data <= prs80_pkg::dec_round(st_r[i-1].data, rk[N+1-i]);
      end
    end
  end

  assign out_vld       = vld_r[N];
  assign out_item.func = st_r[N].func;
  assign out_item.data = st_r[N].data ^
                         ((st_r[N].func == prs80_pkg::FUNC_ENC) ? rk[N] : rk[0]);

endmodule

>>> rtl/present80_block_cipher_unit.sv
// present80_block_cipher_unit: present-80 encrypt/decrypt, one round per pipeline stage
// throughput: one block per cycle while the output is not held
// the key schedule settles through its register levels after a key write
// the whole pipeline stalls while the output is held; the output register is the last stage
// reset (synchronous, rst_n low) clears valid bits and both key registers to zero
// depends on prs80_pkg, prs80_stream_if, prs80_key_sched, prs80_round_pipe
`timescale 1ns / 1ps
module present80_block_cipher_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  prs80_stream_if.sink                        in_s,
  prs80_stream_if.source                      out_s,
  input  logic                                cfg_we,
  input  logic [prs80_pkg::CfgIdxW-1:0]       cfg_idx,
  input  logic [prs80_pkg::CfgDataW-1:0]      cfg_data
);

  prs80_pkg::block_t rk [prs80_pkg::RoundCount+1];
  prs80_pkg::item_t  in_item;
  prs80_pkg::item_t  res_item;
  logic              res_vld;
  logic              adv;

  prs80_key_sched u_ks (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_data, .rk_o(rk)
  );

  assign adv           = !res_vld || out_s.ready;
  assign in_s.ready    = adv;
  assign in_item.func  = in_s.payload[64];
  assign in_item.data  = in_s.payload[63:0];

  prs80_round_pipe u_pipe (
    .clk, .rst_n, .adv, .in_vld(in_s.valid), .in_item, .rk,
    .out_vld(res_vld), .out_item(res_item)
  );

  assign out_s.valid   = res_vld;
  assign out_s.payload = res_item.data;

endmodule

>>> tb/sv/present80_block_cipher_unit_tb.sv
// present80_block_cipher_unit_tb: self-checking test of the present-80 cipher unit
// known-answer vectors and random blocks under several keys, checked against a local cipher model
// depends on prs80_pkg, prs80_stream_if, present80_block_cipher_unit
`timescale 1ns / 1ps
module present80_block_cipher_unit_tb;
  import prs80_pkg::*;

  localparam int NumRandom = 1900;
  localparam int Settle = 40;
  localparam logic [63:0] Ones = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [63:0] khi;
    logic [15:0] klo;
    logic        func;
    block_t      blk;
    bit          known;
    block_t      res;
  } vec_t;

  localparam logic [3:0] SBF [16] = '{4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
                                      4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2};
  localparam logic [3:0] SBI [16] = '{4'h5, 4'hE, 4'hF, 4'h8, 4'hC, 4'h1, 4'h2, 4'hD,
                                      4'hB, 4'h4, 4'h6, 4'h3, 4'h0, 4'h7, 4'h9, 4'hA};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = REG_KEY_UPPER;
  logic [CfgDataW-1:0] cfg_data = '0;

  prs80_stream_if #(.W(BlockW + 1)) in_if ();
  prs80_stream_if #(.W(BlockW)) out_if ();

  present80_block_cipher_unit u_top (
    .clk(clk), .rst_n(rst_n), .in_s(in_if.sink), .out_s(out_if.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  logic [63:0] key_hi = '0;
  logic [15:0] key_lo = '0;
  block_t cipher_q [$];
  int errors = 0;
  bit idle_on = 1'b1;
  bit hold_go = 1'b0;
  int hold_cnt = 0;
  int rx_gap = 0;
  vec_t dir_tab [14];

  function automatic block_t present_cipher(input logic func, input block_t blk,
                                            input logic [63:0] khi, input logic [15:0] klo);
    logic [79:0] k;
    block_t rk [32];
    block_t s;
    block_t t;
    k = {khi, klo};
    rk[0] = k[79:16];
    for (int i = 1; i < 32; i++) begin
      k = {k[18:0], k[79:19]};
      k[79:76] = SBF[k[79:76]];
      k[19:15] = k[19:15] ^ i[4:0];
      rk[i] = k[79:16];
    end
    s = blk;
    if (func == FUNC_ENC) begin
      for (int r = 0; r < 31; r++) begin
        s = s ^ rk[r];
        for (int n = 0; n < 16; n++) t[4*n +: 4] = SBF[s[4*n +: 4]];
        for (int j = 0; j < 64; j++) s[(j == 63) ? 63 : (16 * j) % 63] = t[j];
      end
      s = s ^ rk[31];
    end else begin
      for (int r = 31; r > 0; r--) begin
        s = s ^ rk[r];
        for (int j = 0; j < 64; j++) t[j] = s[(j == 63) ? 63 : (16 * j) % 63];
        for (int n = 0; n < 16; n++) s[4*n +: 4] = SBI[t[4*n +: 4]];
      end
      s = s ^ rk[0];
    end
    return s;
  endfunction

  // result checking and expectation capture, sampled mid-cycle
  always @(negedge clk) begin
    if (rst_n && in_if.valid && in_if.ready)
      cipher_q.push_back(present_cipher(in_if.payload[BlockW], in_if.payload[BlockW-1:0],
                                        key_hi, key_lo));
    if (rst_n && out_if.valid && out_if.ready) begin
      if (cipher_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transaction: got %h", out_if.payload);
      end else begin
        if (out_if.payload !== cipher_q[0]) begin
          errors++;
          if (errors <= 10)
            $display("mismatch block_out: exp %h got %h", cipher_q[0], out_if.payload);
        end
        void'(cipher_q.pop_front());
      end
    end
  end

  // receiver with random stalls and one long hold-off
  initial out_if.ready = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_go) begin
      hold_go <= 1'b0;
      hold_cnt <= 300;
      out_if.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_if.ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      out_if.ready <= (rx_gap == 1);
    end else if (idle_on && $urandom_range(0, 11) == 0) begin
      rx_gap <= $urandom_range(1, 16);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  task automatic send_block(input logic func, input block_t blk);
    bit acc;
    if (idle_on && $urandom_range(0, 9) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.payload <= {func, blk};
    do begin
      @(negedge clk);
      acc = in_if.ready;
      @(posedge clk);
    end while (!acc);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (cipher_q.size() != 0) @(posedge clk);
    repeat (Settle) @(posedge clk);
  endtask

  task automatic load_key(input logic [63:0] khi, input logic [15:0] klo);
    drain();
    cfg_we <= 1'b1;
    cfg_idx <= REG_KEY_UPPER;
    cfg_data <= khi;
    @(posedge clk);
    // upper bits of the lower key word carry junk that must be masked
    cfg_idx <= REG_KEY_LOWER;
    cfg_data <= {$urandom(), 16'($urandom_range(0, 65535)), klo};
    @(posedge clk);
    cfg_we <= 1'b0;
    key_hi = khi;
    key_lo = klo;
    repeat (Settle) @(posedge clk);
  endtask

  function automatic block_t rand_block();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return Ones;
      2: return block_t'(1) << $urandom_range(0, 63);
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  initial begin
    logic [63:0] khi;
    logic [15:0] klo;
    block_t blk;
    in_if.valid = 1'b0;
    in_if.payload = '0;
    dir_tab = '{
      '{64'h0, 16'h0, FUNC_ENC, 64'h0, 1, 64'h5579C1387B228445},
      '{64'h0, 16'h0, FUNC_ENC, Ones, 1, 64'hA112FFC72F68417B},
      '{64'h0, 16'h0, FUNC_DEC, 64'h5579C1387B228445, 1, 64'h0},
      '{64'h0, 16'h0, FUNC_DEC, 64'hA112FFC72F68417B, 1, Ones},
      '{64'h0, 16'h0, FUNC_ENC, 64'h8000000000000000, 0, 64'h0},
      '{64'h0, 16'h0, FUNC_DEC, 64'h0000000000000001, 0, 64'h0},
      '{Ones, 16'hFFFF, FUNC_ENC, 64'h0, 1, 64'hE72C46C0F5945049},
      '{Ones, 16'hFFFF, FUNC_ENC, Ones, 1, 64'h3333DCD3213210D2},
      '{Ones, 16'hFFFF, FUNC_DEC, 64'h3333DCD3213210D2, 1, Ones},
      '{Ones, 16'hFFFF, FUNC_DEC, 64'hE72C46C0F5945049, 1, 64'h0},
      '{64'h0123456789ABCDEF, 16'h1357, FUNC_ENC, 64'hDEADBEEFCAFEF00D, 0, 64'h0},
      '{64'h0123456789ABCDEF, 16'h1357, FUNC_DEC, 64'hDEADBEEFCAFEF00D, 0, 64'h0},
      '{64'h8000000000000000, 16'h0001, FUNC_ENC, 64'hAAAAAAAAAAAAAAAA, 0, 64'h0},
      '{64'h8000000000000000, 16'h0001, FUNC_DEC, 64'h5555555555555555, 0, 64'h0}
    };
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (Settle) @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].khi !== key_hi || dir_tab[i].klo !== key_lo)
        load_key(dir_tab[i].khi, dir_tab[i].klo);
      // typed-in answers must also agree with the local model
      if (dir_tab[i].known &&
          present_cipher(dir_tab[i].func, dir_tab[i].blk, key_hi, key_lo) !== dir_tab[i].res) begin
        errors++;
        $display("known vector %0d: exp %h", i, dir_tab[i].res);
      end
      send_block(dir_tab[i].func, dir_tab[i].blk);
    end

    for (int n = 0; n < NumRandom; n++) begin
      if (n % 250 == 0) begin
        case ((n / 250) % 4)
          0: begin khi = {$urandom(), $urandom()}; klo = 16'($urandom_range(0, 65535)); end
          1: begin khi = Ones; klo = 16'h0; end
          2: begin khi = '0; klo = 16'hFFFF; end
          default: begin khi = rand_block(); klo = 16'($urandom_range(0, 65535)); end
        endcase
        load_key(khi, klo);
      end
      if (n == 600) hold_go <= 1'b1;
      if (n == NumRandom - 200) idle_on = 1'b0;
      blk = rand_block();
      send_block(1'($urandom_range(0, 1)), blk);
    end

    drain();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/prs80_pkg.sv
rtl/prs80_stream_if.sv
rtl/prs80_key_sched.sv
rtl/prs80_round_pipe.sv
rtl/present80_block_cipher_unit.sv
tb/sv/present80_block_cipher_unit_tb.sv
